// ===== hw/rtl/iufp_pkg.sv =====
// ----------------------------------------------------------------------------
// iufp_pkg
// Shared types and constants for the inertial sensor serial frame parser.
// ----------------------------------------------------------------------------
package iufp_pkg;

   localparam logic [7:0]  HDR0        = 8'hAA;
   localparam logic [7:0]  HDR1        = 8'h00;
   localparam int          PAYLOAD_LEN = 12;
   localparam logic [3:0]  CHK_IDX     = 4'd12;
   localparam logic [3:0]  FRAME_LEN   = 4'd13;
   localparam logic [15:0] SENTINEL    = 16'h7FFF;

   // heading = ((-raw + 36005) mod 36000) / 10
   localparam logic signed [17:0] HEAD_BIAS = 18'sd36005;
   localparam logic [17:0]        HEAD_MOD  = 18'd36000;
   // x / 10 == (x * 52429) >> 19, exact for x below 36000
   localparam logic [15:0]        RECIP_10  = 16'd52429;
   localparam int                 RECIP_SH  = 19;
   localparam int                 HEAD_W    = 12;

   localparam logic OP_BYTE   = 1'b0;
   localparam logic OP_REZERO = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_HDR  = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   typedef logic [PAYLOAD_LEN-1:0][7:0] payload_type;

   // per-item event from the framer to the decoder
   typedef struct packed {
      logic        done;     // checksum byte (13th after the header) processed
      logic        ok;       // checksum matched
      logic        rezero;   // rezero item processed
      payload_type payload;
   } frm_evt_type;

endpackage

// ===== hw/rtl/iufp_framer.sv =====
// ----------------------------------------------------------------------------
// iufp_framer
// Header hunt, payload byte store and running checksum.
// ----------------------------------------------------------------------------
module iufp_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  opcode,
   input  logic [7:0]            rx_byte,
   output iufp_pkg::frm_evt_type evt
);

   iufp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [7:0]          csum_ff, csum_in;
   logic [7:0]          bytes_ff [iufp_pkg::PAYLOAD_LEN];
   logic [3:0]          idx;
   logic                store;
   logic                done;
   logic                ok;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      csum_in  = csum_ff;
      idx      = (cnt_ff >= iufp_pkg::FRAME_LEN) ? 4'd0 : cnt_ff;
      store    = 1'b0;
      done     = 1'b0;
      ok       = 1'b0;
      if (fire && opcode == iufp_pkg::OP_BYTE) begin
         unique case (phase_ff)
            iufp_pkg::PH_HDR: begin
               if (rx_byte == iufp_pkg::HDR1) begin
                  phase_in = iufp_pkg::PH_BODY;
               end else begin
                  phase_in = iufp_pkg::PH_HUNT;
                  cnt_in   = 4'd0;
               end
            end
            iufp_pkg::PH_BODY: begin
               if (idx == iufp_pkg::CHK_IDX) begin
                  done     = 1'b1;
                  ok       = (csum_ff == rx_byte);
                  cnt_in   = 4'd0;
                  phase_in = iufp_pkg::PH_HUNT;
               end else begin
                  store   = 1'b1;
                  cnt_in  = idx + 4'd1;
                  csum_in = (idx == 4'd0) ? rx_byte : csum_ff + rx_byte;
               end
            end
            default: begin
               phase_in = (rx_byte == iufp_pkg::HDR0) ? iufp_pkg::PH_HDR : iufp_pkg::PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= iufp_pkg::PH_HUNT;
         cnt_ff   <= 4'd0;
         csum_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         csum_ff  <= csum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         bytes_ff[idx] <= rx_byte;
      end
   end

   always_comb begin
      evt.done   = done;
      evt.ok     = ok;
      evt.rezero = fire && opcode == iufp_pkg::OP_REZERO;
      for (int k = 0; k < iufp_pkg::PAYLOAD_LEN; k++) begin
         evt.payload[k] = bytes_ff[k];
      end
   end

endmodule

// ===== hw/rtl/iufp_decode.sv =====
// ----------------------------------------------------------------------------
// iufp_decode
// Field decode, heading odometer, acceleration offsets and result register.
// ----------------------------------------------------------------------------
module iufp_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  iufp_pkg::frm_evt_type evt,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [175:0]          rsp_tdata,
   output logic                  rsp_tuser
);

   logic [15:0] head_word;
   logic signed [17:0] head_biased;
   logic [17:0] head_wrap;
   logic [31:0] head_prod;
   logic [iufp_pkg::HEAD_W-1:0] head_pend_ff;

   logic [7:0]  index_ff, index_in;
   logic [15:0] rate_ff, rate_in;
   logic [iufp_pkg::HEAD_W-1:0] heading_ff, heading_in;
   logic [31:0] odo_ff, odo_in;
   logic [15:0] acc_ff [3];
   logic [15:0] acc_in [3];
   logic [15:0] ofs_ff [3];
   logic [15:0] ofs_in [3];
   logic [7:0]  calib_ff, calib_in;
   logic        good;

   logic         rsp_vld_ff, rsp_vld_in;
   logic         rsp_ok_ff;
   logic [175:0] rsp_data_ff, rsp_data_in;

   // heading is computed ahead from stored bytes 1..2, long before the frame ends
   always_comb begin
      head_word   = {evt.payload[2], evt.payload[1]};
      head_biased = iufp_pkg::HEAD_BIAS - {{2{head_word[15]}}, head_word};
      head_wrap   = (unsigned'(head_biased) >= iufp_pkg::HEAD_MOD) ?
                    unsigned'(head_biased) - iufp_pkg::HEAD_MOD : unsigned'(head_biased);
      head_prod   = head_wrap[15:0] * iufp_pkg::RECIP_10;
   end

   always_ff @(posedge clock) begin
      head_pend_ff <= head_prod[iufp_pkg::RECIP_SH +: iufp_pkg::HEAD_W];
   end

   always_comb begin
      good       = evt.done && evt.ok;
      index_in   = index_ff;
      rate_in    = rate_ff;
      heading_in = heading_ff;
      odo_in     = odo_ff;
      calib_in   = calib_ff;
      for (int k = 0; k < 3; k++) begin
         acc_in[k] = acc_ff[k];
         ofs_in[k] = ofs_ff[k];
      end
      if (good) begin
         index_in   = evt.payload[0];
         rate_in    = 16'd0 - {evt.payload[4], evt.payload[3]};
         heading_in = head_pend_ff;
         odo_in     = odo_ff + {20'd0, head_pend_ff} - {20'd0, heading_ff};
         acc_in[0]  = 16'd0 - {evt.payload[8], evt.payload[7]};
         acc_in[1]  = {evt.payload[6], evt.payload[5]};
         acc_in[2]  = 16'd0 - {evt.payload[10], evt.payload[9]};
         calib_in   = evt.payload[11];
         for (int k = 0; k < 3; k++) begin
            if (ofs_ff[k] == iufp_pkg::SENTINEL) begin
               ofs_in[k] = acc_in[k];
            end
         end
      end else if (evt.rezero) begin
         odo_in   = 32'd0;
         calib_in = 8'd0;
         for (int k = 0; k < 3; k++) begin
            ofs_in[k] = acc_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= 8'd0;
         rate_ff    <= 16'd0;
         heading_ff <= '0;
         odo_ff     <= 32'd0;
         calib_ff   <= 8'd0;
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= 16'd0;
            ofs_ff[k] <= iufp_pkg::SENTINEL;
         end
      end else begin
         index_ff   <= index_in;
         rate_ff    <= rate_in;
         heading_ff <= heading_in;
         odo_ff     <= odo_in;
         calib_ff   <= calib_in;
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= acc_in[k];
            ofs_ff[k] <= ofs_in[k];
         end
      end
   end

   // result register
   always_comb begin
      rsp_data_in = {4'd0,
                     calib_in,
                     acc_in[2] - ofs_in[2],
                     acc_in[1] - ofs_in[1],
                     acc_in[0] - ofs_in[0],
                     acc_in[2],
                     acc_in[1],
                     acc_in[0],
                     odo_in,
                     heading_in,
                     rate_in,
                     index_in};
      rsp_vld_in = evt.done ? 1'b1 : (rsp_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evt.done) begin
         rsp_data_ff <= rsp_data_in;
         rsp_ok_ff   <= evt.ok;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

endmodule

// ===== hw/rtl/imu_uart_frame_parser.sv =====
// ----------------------------------------------------------------------------
// imu_uart_frame_parser
// Serial frame parser for an inertial sensor: header hunt, checksum, decode.
// ----------------------------------------------------------------------------
// Takes one item per clock: a received serial byte or a rezero command
// (req_tuser). After the header 0xAA 0x00 it gathers 12 payload bytes and a
// checksum byte; the checksum byte yields one result with checksum_ok in
// rsp_tuser, holding the previous values when the checksum fails. Each item
// passes an input register and one decode stage, so a result is registered
// as its checksum byte leaves the input register. A new item is taken every
// cycle unless a result is waiting on rsp_tready. The heading divide by ten
// is a single 16x16 reciprocal multiply, registered ahead of the frame end
// from the stored heading bytes.
// ----------------------------------------------------------------------------
module imu_uart_frame_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // rx_byte
   input  logic         req_tuser,   // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // frame_index, rate, heading, odometer, accel_x, accel_y, accel_z,
   // accel_x_diff, accel_y_diff, accel_z_diff, calib_status, zero pad
   output logic [175:0] rsp_tdata,
   output logic         rsp_tuser    // checksum_ok
);

   logic                  in_vld_ff, in_vld_in;
   logic                  in_op_ff;
   logic [7:0]            in_byte_ff;
   logic                  go;
   logic                  fire;
   iufp_pkg::frm_evt_type evt;

   assign go         = !rsp_tvalid || rsp_tready;
   assign fire       = in_vld_ff && go;
   assign req_tready = !in_vld_ff || go;
   assign in_vld_in  = (req_tvalid && req_tready) ? 1'b1 : (in_vld_ff && !go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   iufp_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .opcode  (in_op_ff),
      .rx_byte (in_byte_ff),
      .evt     (evt)
   );

   iufp_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // heading always within 0..3599 tenths of a degree
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:24] < 12'd3600)
      else $error("heading out of range");

   // a fresh result comes only from an item held in the input register
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid && !rsp_tready) |-> $past(in_vld_ff))
      else $error("result without a processed item");

   // a held item is not dropped while the result side stalls
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && rsp_tvalid && !rsp_tready |=> in_vld_ff)
      else $error("input item lost during stall");

endmodule
